/* rtl/stis_pkg.sv */
// Package for the sorted table interval search block.
// Holds widths, command codes, register addresses and the value conversion function.
// No dependencies.
package stis_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int VALUE_W     = 32;
    localparam int DATA_W      = 32;
    localparam int IDX_W       = 10;
    localparam int POS_W       = 10;
    localparam int CFG_W       = 11;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int BOUND_W     = ADDR_W + 2;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    typedef logic [VALUE_W-1:0] t_value;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // Register index is the word address, paddr[2].
    localparam logic REG_ENTRIES_IN_USE = 1'b0;

    // Sign-extend the request data and keep the low VALUE_W bits.
    function automatic t_value to_value(input logic [DATA_W-1:0] d);
        logic [63:0] ext;
        ext = 64'($signed(d));
        return ext[VALUE_W-1:0];
    endfunction

endpackage

/* rtl/stis_if.sv */
// Request and result channel interfaces of the sorted table interval search block.
// Depends on stis_pkg for field widths.
interface stis_req_if;
    logic                             valid;
    logic                             ready;
    logic                             cmd;
    logic [stis_pkg::IDX_W-1:0]       entry_index;
    logic signed [stis_pkg::DATA_W-1:0] data_value;

    modport source(output valid, cmd, entry_index, data_value, input ready);
    modport sink(input valid, cmd, entry_index, data_value, output ready);
endinterface

interface stis_res_if;
    logic                       valid;
    logic                       ready;
    logic                       found;
    logic [stis_pkg::POS_W-1:0] position;

    modport source(output valid, found, position, input ready);
    modport sink(input valid, found, position, output ready);
endinterface

/* rtl/sorted_table_interval_search.sv */
// Top level of the sorted table interval search block: table memory, bisection sequencer,
// result register and APB configuration register.
// Depends on stis_pkg and the interfaces in stis_if.sv.
//
//  Channel   Direction  Handshake              Payload
//  i_req     in         valid/ready            cmd, entry_index, data_value
//  o_res     out        valid/ready            found, position
//  APB       in/out     psel/penable/pready    paddr, pwdata, prdata (entries_in_use)
//
// A write request is taken in the idle state and gives no result. A search request runs each
// probe as two states (S_READ reads the table at the midpoint and its successor, S_CMP compares),
// at most 11 probes for 1024 entries, then S_FINISH loads the result register once it is free.
// An empty table goes straight to S_FINISH with no probe.
// Reset is synchronous and active low; it clears the sequencer, the result register and
// entries_in_use, but not the table, which must be written before it is searched.
// The request side is ready only when the sequencer is idle. A finished result waits in the
// sequencer while the result register is still held by a stalled sink.
module sorted_table_interval_search (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    stis_req_if.sink                      i_req,
    stis_res_if.source                    o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [stis_pkg::PADDR_W-1:0]  paddr,
    input  logic [stis_pkg::PDATA_W-1:0]  pwdata,
    output logic [stis_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_FINISH
    } t_state;

    // Table memory, two read ports, one write port.
    stis_pkg::t_value mem [stis_pkg::TABLE_DEPTH];

    t_state                                r_state;
    logic [stis_pkg::CFG_W-1:0]            r_entries;
    logic [stis_pkg::CNT_W-1:0]            r_size;
    logic signed [stis_pkg::BOUND_W-1:0]   r_lo;
    logic signed [stis_pkg::BOUND_W-1:0]   r_hi;
    logic [stis_pkg::ADDR_W-1:0]           r_m;
    stis_pkg::t_value                      r_key;
    stis_pkg::t_value                      r_here;
    stis_pkg::t_value                      r_next;
    logic                                  r_res_found;
    logic [stis_pkg::POS_W-1:0]            r_res_pos;
    logic                                  r_out_valid;
    logic                                  r_out_found;
    logic [stis_pkg::POS_W-1:0]            r_out_pos;

    logic                                  req_accept;
    logic                                  cfg_write;
    logic                                  res_free;
    logic [stis_pkg::CNT_W-1:0]            size_c;
    logic signed [stis_pkg::BOUND_W-1:0]   diff_c;
    logic signed [stis_pkg::BOUND_W-1:0]   mid_c;
    logic [stis_pkg::ADDR_W-1:0]           rd_addr;
    logic [stis_pkg::ADDR_W-1:0]           rd_addr_next;
    logic                                  is_last;
    logic                                  key_ge_here;
    logic                                  key_le_next;
    logic                                  hit;
    logic signed [stis_pkg::BOUND_W-1:0]   m_ext;
    logic signed [stis_pkg::BOUND_W-1:0]   lo_next;
    logic signed [stis_pkg::BOUND_W-1:0]   hi_next;
    logic                                  go_up;
    logic                                  range_empty;

    assign i_req.ready = (r_state == S_IDLE);
    assign req_accept  = i_req.valid && i_req.ready;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == stis_pkg::REG_ENTRIES_IN_USE);
    assign prdata    = (paddr[2] == stis_pkg::REG_ENTRIES_IN_USE)
                       ? stis_pkg::PDATA_W'(r_entries) : '0;

    assign o_res.valid    = r_out_valid;
    assign o_res.found    = r_out_found;
    assign o_res.position = r_out_pos;
    assign res_free       = !r_out_valid || o_res.ready;

    // Counts above the table depth search the whole table.
    assign size_c = (r_entries > stis_pkg::CFG_W'(stis_pkg::TABLE_DEPTH))
                    ? stis_pkg::CNT_W'(stis_pkg::TABLE_DEPTH)
                    : stis_pkg::CNT_W'(r_entries);

    // Midpoint of the live range; lo never exceeds hi here, so the difference is not negative.
    assign diff_c       = r_hi - r_lo;
    assign mid_c        = r_lo + (diff_c >>> 1);
    assign rd_addr      = mid_c[stis_pkg::ADDR_W-1:0];
    assign rd_addr_next = rd_addr + stis_pkg::ADDR_W'(1);

    // The entry after the last searched one counts as plus infinity.
    assign is_last     = (stis_pkg::CNT_W'(r_m) + stis_pkg::CNT_W'(1)) >= r_size;
    assign key_ge_here = $signed(r_key) >= $signed(r_here);
    assign key_le_next = $signed(r_key) <= $signed(r_next);
    assign hit         = key_ge_here && (is_last || key_le_next);

    assign m_ext       = $signed({2'b00, r_m});
    assign lo_next     = m_ext + stis_pkg::BOUND_W'(1);
    assign hi_next     = m_ext - stis_pkg::BOUND_W'(1);
    assign go_up       = $signed(r_here) < $signed(r_key);
    assign range_empty = go_up ? (lo_next > r_hi) : (r_lo > hi_next);

    always_ff @(posedge i_clk) begin
        if (req_accept && (i_req.cmd == stis_pkg::CMD_WRITE)) begin
            mem[i_req.entry_index] <= stis_pkg::to_value(i_req.data_value);
        end
        if (r_state == S_READ) begin
            r_here <= mem[rd_addr];
            r_next <= mem[rd_addr_next];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_entries   <= '0;
            r_out_valid <= 1'b0;
            r_out_found <= 1'b0;
            r_out_pos   <= '0;
            r_size      <= '0;
            r_lo        <= '0;
            r_hi        <= '0;
            r_m         <= '0;
            r_key       <= '0;
            r_res_found <= 1'b0;
            r_res_pos   <= '0;
        end else begin
            if (cfg_write) begin
                r_entries <= pwdata[stis_pkg::CFG_W-1:0];
            end
            // In the finishing state the result register is reloaded below instead.
            if (r_out_valid && o_res.ready && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (req_accept && (i_req.cmd == stis_pkg::CMD_SEARCH)) begin
                        r_key  <= stis_pkg::to_value(i_req.data_value);
                        r_size <= size_c;
                        r_lo   <= '0;
                        r_hi   <= $signed({1'b0, size_c}) - stis_pkg::BOUND_W'(1);
                        if (size_c == '0) begin
                            // An empty table gives not found straight away.
                            r_res_found <= 1'b0;
                            r_res_pos   <= '0;
                            r_state     <= S_FINISH;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_m     <= rd_addr;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (hit) begin
                        r_res_found <= 1'b1;
                        r_res_pos   <= stis_pkg::POS_W'(r_m);
                        r_state     <= S_FINISH;
                    end else begin
                        if (go_up) begin
                            r_lo <= lo_next;
                        end else begin
                            r_hi <= hi_next;
                        end
                        if (range_empty) begin
                            r_res_found <= 1'b0;
                            r_res_pos   <= '0;
                            r_state     <= S_FINISH;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_FINISH: begin
                    if (res_free) begin
                        r_out_valid <= 1'b1;
                        r_out_found <= r_res_found;
                        r_out_pos   <= r_res_pos;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/stis_checker.sv */
// Port-level checker for the sorted table interval search block, and its bind statement.
// Depends on stis_pkg and on the top level sorted_table_interval_search.
module stis_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_req_valid,
    input logic                       i_req_ready,
    input logic                       i_req_cmd,
    input logic                       i_res_valid,
    input logic                       i_res_ready,
    input logic                       i_res_found,
    input logic [stis_pkg::POS_W-1:0] i_res_position
);

    // A stalled result keeps its valid.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result valid dropped while stalled");

    // A stalled result keeps its payload.
    a_res_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> $stable(i_res_found) && $stable(i_res_position))
        else $error("result payload changed while stalled");

    // A result without a found interval reports position zero.
    a_miss_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_found |-> i_res_position == '0)
        else $error("not found result with nonzero position");

    // A search request busies the block for at least the following cycle.
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && (i_req_cmd == stis_pkg::CMD_SEARCH) |=> !i_req_ready)
        else $error("request taken in the cycle after a search");

endmodule

bind sorted_table_interval_search stis_checker u_stis_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_req_cmd      (i_req.cmd),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_res_found    (o_res.found),
    .i_res_position (o_res.position)
);
